/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion wrappers used by the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, masked while rst is high
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// clocked assertion that also holds through reset
`define ASSERT_CLK_RST(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* rtl/kip_pkg.sv */
// ----------------------------------------------------------------------------
// kip_pkg
// Shared constants, types and helpers of the keyed index permutation unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package kip_pkg;

  localparam int ROUNDS    = 1024;
  localparam int ROUND_W   = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;
  localparam int KEY_W     = 32;
  localparam int IDX_W     = 32;
  localparam int VAL_W     = 31;
  localparam int WBITS_W   = 5;
  localparam int TDATA_W   = 32;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DW    = 32;

  localparam logic [KEY_W-1:0] VALUE_SALT = 32'h5aa5_5aa5;
  localparam logic [KEY_W-1:0] KEY_SALT   = 32'haa55_aa55;
  localparam logic [WBITS_W-1:0] WIDTH_RESET = 5'd20;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH_BITS = 1'b0,
    REG_SEED       = 1'b1
  } cfg_reg_t;

  // domain mask and the one-hot of its top bit
  typedef struct packed {
    logic [VAL_W-1:0] mask;
    logic [VAL_W-1:0] top;
  } width_cfg_t;

  function automatic logic [KEY_W-1:0] bit_rev32(input logic [KEY_W-1:0] x);
    logic [KEY_W-1:0] r;
    for (int k = 0; k < KEY_W; k++) begin
      r[k] = x[KEY_W-1-k];
    end
    return r;
  endfunction

  function automatic logic [KEY_W-1:0] key_step(input logic [KEY_W-1:0] k);
    logic [KEY_W-1:0] s;
    s = k + KEY_W'(1);
    return {s[KEY_W-2:0], s[KEY_W-1]};
  endfunction

  function automatic width_cfg_t width_decode(input logic [WBITS_W-1:0] wb);
    logic [WBITS_W-1:0] w;
    width_cfg_t c;
    w = (wb == '0) ? WBITS_W'(1) : wb;
    c.mask = (VAL_W'(1) << w) - VAL_W'(1);
    c.top  = VAL_W'(1) << (w - WBITS_W'(1));
    return c;
  endfunction

endpackage

`default_nettype wire

/* rtl/kip_key_sched.sv */
// ----------------------------------------------------------------------------
// kip_key_sched
// Per-round key chain; each entry is a registered key_step of the one before it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kip_key_sched import kip_pkg::*; (
  input  wire logic             clk,
  input  wire logic [KEY_W-1:0] key0,
  output logic      [KEY_W-1:0] keys [ROUNDS]
);

  for (genvar r = 0; r < ROUNDS; r++) begin : g_key
    if (r == 0) begin : g_first
      assign keys[r] = key0;
    end else begin : g_next
      always_ff @(posedge clk) begin
        keys[r] <= key_step(keys[r-1]);
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/kip_round.sv */
// ----------------------------------------------------------------------------
// kip_round
// One scramble round: add round number, mix key, rotate within the domain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kip_round import kip_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               en,
  input  wire width_cfg_t         wcfg,
  input  wire logic [ROUND_W-1:0] rnd,
  input  wire logic [KEY_W-1:0]   key,
  input  wire logic               in_valid,
  input  wire logic [VAL_W-1:0]   in_value,
  output logic                    out_valid,
  output logic      [VAL_W-1:0]   out_value
);

  logic [VAL_W-1:0] mixed;
  logic             wrap;
  logic [VAL_W-1:0] value_next;

  always_comb begin
    mixed      = (in_value + VAL_W'(rnd)) ^ key[VAL_W-1:0];
    wrap       = |(mixed & wcfg.top);
    value_next = ({mixed[VAL_W-2:0], 1'b0} | VAL_W'(wrap)) & wcfg.mask;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_value <= value_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/kip_out_buf.sv */
// ----------------------------------------------------------------------------
// kip_out_buf
// Output register with a skid entry; frees the pipeline from the sink.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kip_out_buf import kip_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  input  wire logic [VAL_W-1:0] in_value,
  output logic                  in_ready,
  output logic                  out_valid,
  output logic      [VAL_W-1:0] out_value,
  input  wire logic             out_ready
);

  logic             skid_valid;
  logic [VAL_W-1:0] skid_value;
  logic             push;
  logic             pop;

  assign in_ready = !skid_valid;
  assign push     = in_valid && in_ready;
  assign pop      = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (out_valid && !pop) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        out_value <= skid_value;
      end
    end else if (push) begin
      if (out_valid && !pop) begin
        skid_value <= in_value;
      end else begin
        out_value <= in_value;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/keyed_index_permutation_unit.sv */
// ----------------------------------------------------------------------------
// keyed_index_permutation_unit
// Keyed bijective index scrambler, one round per pipeline stage.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle while s_tready is high; one input register,
// one register per round.
// Round keys come from a register chain that trails a seed write round by round,
// so it is ready for any word accepted on or after the write.
// Reset: synchronous, clears all valid bits; width_bits -> 20, seed -> 0.
`timescale 1ns / 1ps
`default_nettype none

module keyed_index_permutation_unit import kip_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_wen,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_DW-1:0]    cfg_wdata,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [TDATA_W-1:0]   s_tdata,   // [30:0] index, [31] ignored
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic      [TDATA_W-1:0]   m_tdata    // [30:0] value, [31] zero
);

  width_cfg_t       wcfg;
  logic [KEY_W-1:0] key0;
  logic [KEY_W-1:0] keys [ROUNDS];

  logic             stv   [ROUNDS+1];
  logic [VAL_W-1:0] stval [ROUNDS+1];
  logic             en;
  logic [VAL_W-1:0] out_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      wcfg <= width_decode(WIDTH_RESET);
      key0 <= KEY_SALT;
    end else if (cfg_wen) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_WIDTH_BITS: wcfg <= width_decode(cfg_wdata[WBITS_W-1:0]);
        REG_SEED:       key0 <= bit_rev32(cfg_wdata[KEY_W-1:0]) ^ KEY_SALT;
        default: ;
      endcase
    end
  end

  kip_key_sched u_keys (
    .clk  (clk),
    .key0 (key0),
    .keys (keys)
  );

  assign s_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      stv[0] <= 1'b0;
    end else if (en) begin
      stv[0] <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stval[0] <= s_tdata[VAL_W-1:0] ^ VALUE_SALT[VAL_W-1:0];
    end
  end

  for (genvar r = 0; r < ROUNDS; r++) begin : g_round
    kip_round u_round (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .wcfg      (wcfg),
      .rnd       (ROUND_W'(r)),
      .key       (keys[r]),
      .in_valid  (stv[r]),
      .in_value  (stval[r]),
      .out_valid (stv[r+1]),
      .out_value (stval[r+1])
    );
  end

  kip_out_buf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (stv[ROUNDS]),
    .in_value  (stval[ROUNDS]),
    .in_ready  (en),
    .out_valid (m_tvalid),
    .out_value (out_value),
    .out_ready (m_tready)
  );

  assign m_tdata = TDATA_W'(out_value);

endmodule

`default_nettype wire

/* rtl/kip_checker.sv */
// ----------------------------------------------------------------------------
// kip_checker
// Port-level checks of the permutation unit, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module kip_checker import kip_pkg::*; (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               s_tready,
  input wire logic               m_tvalid,
  input wire logic               m_tready,
  input wire logic [TDATA_W-1:0] m_tdata
);

  `ASSERT_CLK_RST(a_rst_clears_out, rst |=> !m_tvalid, "output word valid after reset")
  `ASSERT_CLK(a_out_hold, m_tvalid && !m_tready |=> m_tvalid, "stalled output word dropped")
  `ASSERT_CLK(a_pad_zero, m_tvalid |-> !m_tdata[TDATA_W-1], "output pad bit set")
  `ASSERT_CLK(a_ready_when_empty, !m_tvalid |-> s_tready, "input stalled with output empty")

endmodule

bind keyed_index_permutation_unit kip_checker u_kip_checker (
  .clk       (clk),
  .rst       (rst),
  .s_tready  (s_tready),
  .m_tvalid  (m_tvalid),
  .m_tready  (m_tready),
  .m_tdata   (m_tdata)
);

`default_nettype wire
